// ===== rtl/rgba_framebuffer_pixel_ops_top_macros.svh =====
// ============================================================================
// RGBA frame store assertion macros
// Shared concurrent assertion forms used by the frame store RTL.
// ============================================================================
`ifndef RGBA_FRAMEBUFFER_PIXEL_OPS_TOP_MACROS_SVH
`define RGBA_FRAMEBUFFER_PIXEL_OPS_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define RFPO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define RFPO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rfpo_pkg.sv =====
// ============================================================================
// RGBA frame store package
// Types, codes and sizes shared by the frame store modules.
// ============================================================================
package rfpo_pkg;

    // Store geometry.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W       = $clog2(STORE_WORDS);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths.
    localparam int CFG_W  = 9;
    localparam int POS_W  = 10;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 4 * CHAN_W;
    localparam int MIX_W  = 9;
    localparam int CMD_W  = 3;

    localparam logic [CFG_W-1:0]  FRAME_SIZE_RESET = CFG_W'(256);
    localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'hFF;
    localparam logic [MIX_W-1:0]  MIX_ONE          = MIX_W'(256);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BLEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Configuration register indexes.
    localparam int               REG_IDX_W        = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [MIX_W-1:0]  mix_factor;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_CLR,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic ram_re;
        logic ram_we;
        logic clr_step;
        logic out_load;
    } t_ctl;

endpackage

// ===== rtl/rfpo_ram.sv =====
// ============================================================================
// Frame store RAM
// Single-port-write, single-port-read synchronous RAM with registered read.
// ============================================================================
module rfpo_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rfpo_alu.sv =====
// ============================================================================
// Frame store pixel ALU
// Computes the new pixel word for write, saturating add and blend.
// ============================================================================
module rfpo_alu (
    input  logic [rfpo_pkg::CMD_W-1:0] i_cmd,
    input  logic [rfpo_pkg::PIX_W-1:0] i_old,
    input  logic [rfpo_pkg::PIX_W-1:0] i_col,
    input  logic [rfpo_pkg::MIX_W-1:0] i_mix,
    output logic [rfpo_pkg::PIX_W-1:0] o_new
);
    import rfpo_pkg::*;

    localparam int BL_W = CHAN_W + MIX_W;

    logic [MIX_W-1:0] w_mix_inv;

    // Weight of the old colour; the mix factor is already limited to one.
    assign w_mix_inv = MIX_ONE - i_mix;

    for (genvar k = 0; k < 4; k++) begin : g_chan
        logic [CHAN_W-1:0] w_old;
        logic [CHAN_W-1:0] w_col;
        logic [CHAN_W:0]   w_sum;
        logic [BL_W-1:0]   w_bl;
        logic [CHAN_W-1:0] w_res;

        assign w_old = i_old[CHAN_W*k +: CHAN_W];
        assign w_col = i_col[CHAN_W*k +: CHAN_W];
        assign w_sum = (CHAN_W+1)'(w_old) + (CHAN_W+1)'(w_col);
        assign w_bl  = BL_W'(w_col) * BL_W'(i_mix) + BL_W'(w_old) * BL_W'(w_mix_inv);

        always_comb begin
            case (i_cmd)
                CMD_WRITE: w_res = w_col;
                CMD_ADD:   w_res = w_sum[CHAN_W] ? CHAN_MAX : w_sum[CHAN_W-1:0];
                CMD_BLEND: w_res = w_bl[BL_W-1] ? CHAN_MAX : w_bl[BL_W-2:CHAN_W];
                default:   w_res = w_old;
            endcase
        end

        assign o_new[CHAN_W*k +: CHAN_W] = w_res;
    end

endmodule

// ===== rtl/rgba_framebuffer_pixel_ops_top.sv =====
// ============================================================================
// RGBA8888 frame store with raster operations
// Pixel write, saturating add, blend and read, plus clear of the active frame.
// ============================================================================
// Usage:
// Commands arrive as beats on the input valid/ready channel, one command per
// beat, and every command returns exactly one result beat on the output
// valid/ready channel. The active frame size is set through the
// configuration channel (index 0 width, index 1 height), which is always
// ready and must only be written while no command is in flight.
// A pixel command in bounds reads the pixel word from the frame RAM, modifies
// it and writes it back: it passes through the read, modify/write-back and
// result states, and the next command is taken in the cycle the result is
// shown. These states are the registered read of the frame RAM plus the
// modify/write-back and result stages. Out-of-bounds and unknown commands
// skip the RAM and go straight to the result stage. Clear all writes one
// word per cycle over the RAM write port until width * height words are written.
// The result sits in an output register, so a stalled receiver does not stop
// the next command from being accepted; the block then waits with its
// finished result until the output register is free.
// Reset (synchronous) returns the control to idle, empties the output
// register and sets the frame size to 256 by 256. Pixel contents are not
// cleared and read as unknown until written.
module rgba_framebuffer_pixel_ops_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rfpo_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rfpo_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rfpo_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [rfpo_pkg::CFG_W-1:0]           i_cfg_data
);
    import rfpo_pkg::*;
    `include "rgba_framebuffer_pixel_ops_top_macros.svh"

    localparam int ROW_W = POS_W + CFG_W;

    // Control state.
    t_state             r_state;
    t_state             n_state;
    t_state             w_entry;
    t_ctl               w_ctl;
    logic [CFG_W-1:0]   r_frame_width;
    logic [CFG_W-1:0]   r_frame_height;
    logic               r_out_valid;

    // Command context captured at accept.
    logic [CMD_W-1:0]   r_cmd;
    logic [IDX_W-1:0]   r_addr;
    logic               r_inb;
    logic [PIX_W-1:0]   r_col;
    logic [MIX_W-1:0]   r_mix;
    logic [CNT_W-1:0]   r_clr_num;
    logic [CNT_W-1:0]   r_clr_cnt;
    t_out               r_res;
    t_out               r_out_data;

    // Accept-side combinational terms.
    logic [CFG_W-1:0]   w_act_w;
    logic [CFG_W-1:0]   w_act_h;
    logic               w_in_fire;
    logic               w_inb;
    logic [ROW_W-1:0]   w_row;
    logic [IDX_W-1:0]   w_addr;
    logic [2*CFG_W-1:0] w_area_full;
    logic [CNT_W-1:0]   w_area;
    t_out               w_acc_res;
    logic               w_clr_last;
    logic               w_clr_go;

    // RAM side.
    logic [IDX_W-1:0]   w_ram_waddr;
    logic [PIX_W-1:0]   w_ram_wdata;
    logic [PIX_W-1:0]   w_ram_rdata;
    logic [PIX_W-1:0]   w_alu_new;

    // The active size is the register value limited to the store maximum.
    assign w_act_w = (32'(r_frame_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : r_frame_width;
    assign w_act_h = (32'(r_frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : r_frame_height;

    assign w_in_fire = i_in_valid && w_ctl.in_ready;

    // Bounds check and row-major word address of the addressed pixel.
    assign w_inb  = (i_in_data.pos_x < POS_W'(w_act_w)) && (i_in_data.pos_y < POS_W'(w_act_h));
    assign w_row  = ROW_W'(i_in_data.pos_y) * ROW_W'(w_act_w);
    assign w_addr = IDX_W'(w_row + ROW_W'(i_in_data.pos_x));

    // Number of words covered by clear all.
    assign w_area_full = (2*CFG_W)'(w_act_w) * (2*CFG_W)'(w_act_h);
    assign w_area      = CNT_W'(w_area_full);

    assign w_clr_last = (CNT_W'(r_clr_cnt + CNT_W'(1)) == r_clr_num);

    // A clear all over a non-empty frame is being accepted.
    assign w_clr_go = w_in_fire && (i_in_data.command == CMD_CLEAR) && (w_area != '0);

    // Result fields known at accept; a pixel command in bounds fills the
    // rest once the RAM has been accessed.
    always_comb begin
        w_acc_res = '0;
        case (i_in_data.command)
            CMD_CLEAR: w_acc_res.ok = 1'b1;
            CMD_READ: begin
                if (!w_inb) begin
                    w_acc_res.out_alpha = CHAN_MAX;
                end
            end
            default: w_acc_res = '0;
        endcase
    end

    // First state of a newly accepted command.
    always_comb begin
        case (i_in_data.command)
            CMD_WRITE, CMD_ADD, CMD_BLEND, CMD_READ: begin
                w_entry = w_inb ? S_RD : S_PUSH;
            end
            CMD_CLEAR: w_entry = (w_area == '0) ? S_PUSH : S_CLR;
            default:   w_entry = S_PUSH;
        endcase
    end

    // Sequencer: next state and control strobes.
    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                w_ctl.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = w_entry;
                end
            end
            S_RD: begin
                w_ctl.ram_re = 1'b1;
                n_state      = S_MOD;
            end
            S_MOD: begin
                // Read data is valid here; everything but a read writes back.
                w_ctl.ram_we = (r_cmd != CMD_READ);
                n_state      = S_PUSH;
            end
            S_CLR: begin
                w_ctl.ram_we   = 1'b1;
                w_ctl.clr_step = 1'b1;
                if (w_clr_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_frame_width  <= FRAME_SIZE_RESET;
            r_frame_height <= FRAME_SIZE_RESET;
        end else begin
            r_state <= n_state;
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd     <= i_in_data.command;
            r_addr    <= w_addr;
            r_inb     <= w_inb;
            r_col     <= {i_in_data.alpha, i_in_data.blue, i_in_data.green, i_in_data.red};
            r_mix     <= (i_in_data.mix_factor > MIX_ONE) ? MIX_ONE : i_in_data.mix_factor;
            r_clr_num <= w_area;
            r_clr_cnt <= '0;
            r_res     <= w_acc_res;
        end else begin
            if (r_state == S_MOD) begin
                r_res.ok <= 1'b1;
                if (r_cmd == CMD_READ) begin
                    r_res.out_red   <= w_ram_rdata[0*CHAN_W +: CHAN_W];
                    r_res.out_green <= w_ram_rdata[1*CHAN_W +: CHAN_W];
                    r_res.out_blue  <= w_ram_rdata[2*CHAN_W +: CHAN_W];
                    r_res.out_alpha <= w_ram_rdata[3*CHAN_W +: CHAN_W];
                end
            end
            if (w_ctl.clr_step) begin
                r_clr_cnt <= CNT_W'(r_clr_cnt + CNT_W'(1));
            end
        end
        if (w_ctl.out_load) begin
            r_out_data <= r_res;
        end
    end

    // Clear all streams the fill colour; pixel commands write the ALU result.
    assign w_ram_waddr = (r_state == S_CLR) ? r_clr_cnt[IDX_W-1:0] : r_addr;
    assign w_ram_wdata = (r_state == S_CLR) ? r_col : w_alu_new;

    rfpo_alu u_alu (
        .i_cmd (r_cmd),
        .i_old (w_ram_rdata),
        .i_col (r_col),
        .i_mix (r_mix),
        .o_new (w_alu_new)
    );

    rfpo_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (PIX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctl.ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ctl.ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    assign o_in_ready  = w_ctl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    `RFPO_ASSERT_IMP(a_we_phase, w_ctl.ram_we, (r_state == S_MOD || r_state == S_CLR), "Stray write")
    `RFPO_ASSERT_IMP(a_rd_inbounds, (r_state == S_RD), r_inb, "RAM read out of bounds")
    `RFPO_ASSERT_IMP(a_clr_range, (r_state == S_CLR), (r_clr_cnt < r_clr_num), "Clear past frame")
    `RFPO_ASSERT_IMP(a_out_hold, (r_out_valid && !i_out_ready), !w_ctl.out_load, "Result lost")
    `RFPO_ASSERT_NXT(a_clr_entry, w_clr_go, (r_state == S_CLR), "Clear all did not start the fill")

endmodule
